@@ hdl/stack_machine_core_top_defines.svh @@
// ----------------------------------------------------------------------------
// stack_machine_core_top_defines.svh
// Assertion macros for the stack machine core RTL.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_CORE_TOP_DEFINES_SVH
`define STACK_MACHINE_CORE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/smc_pkg.sv @@
// ----------------------------------------------------------------------------
// smc_pkg
// Types, codes and helpers shared by the stack machine core modules.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int SMC_MEM_WORDS = 65536;
    localparam int WORD_W = 64;
    localparam int PC_W   = 19;
    localparam int SP_W   = 20;
    localparam int CMD_W  = 3;
    localparam int OP_W   = 6;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 32;

    // host commands
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STEP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd4;

    // run status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXIT    = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd2;
    localparam logic [STAT_W-1:0] ST_HOST    = 3'd3;
    localparam logic [STAT_W-1:0] ST_DIVZ    = 3'd4;
    localparam logic [STAT_W-1:0] ST_IDLE    = 3'd5;

    // instruction opcodes
    localparam logic [OP_W-1:0] OP_LEA  = 6'd0;
    localparam logic [OP_W-1:0] OP_IMM  = 6'd1;
    localparam logic [OP_W-1:0] OP_JMP  = 6'd2;
    localparam logic [OP_W-1:0] OP_JSR  = 6'd3;
    localparam logic [OP_W-1:0] OP_BZ   = 6'd4;
    localparam logic [OP_W-1:0] OP_BNZ  = 6'd5;
    localparam logic [OP_W-1:0] OP_ENT  = 6'd6;
    localparam logic [OP_W-1:0] OP_ADJ  = 6'd7;
    localparam logic [OP_W-1:0] OP_LEV  = 6'd8;
    localparam logic [OP_W-1:0] OP_LI   = 6'd9;
    localparam logic [OP_W-1:0] OP_LC   = 6'd10;
    localparam logic [OP_W-1:0] OP_SI   = 6'd11;
    localparam logic [OP_W-1:0] OP_SC   = 6'd12;
    localparam logic [OP_W-1:0] OP_PSH  = 6'd13;
    localparam logic [OP_W-1:0] OP_OR   = 6'd14;
    localparam logic [OP_W-1:0] OP_XOR  = 6'd15;
    localparam logic [OP_W-1:0] OP_AND  = 6'd16;
    localparam logic [OP_W-1:0] OP_EQ   = 6'd17;
    localparam logic [OP_W-1:0] OP_NE   = 6'd18;
    localparam logic [OP_W-1:0] OP_LT   = 6'd19;
    localparam logic [OP_W-1:0] OP_GT   = 6'd20;
    localparam logic [OP_W-1:0] OP_LE   = 6'd21;
    localparam logic [OP_W-1:0] OP_GE   = 6'd22;
    localparam logic [OP_W-1:0] OP_SHL  = 6'd23;
    localparam logic [OP_W-1:0] OP_SHR  = 6'd24;
    localparam logic [OP_W-1:0] OP_ADD  = 6'd25;
    localparam logic [OP_W-1:0] OP_SUB  = 6'd26;
    localparam logic [OP_W-1:0] OP_MUL  = 6'd27;
    localparam logic [OP_W-1:0] OP_DIV  = 6'd28;
    localparam logic [OP_W-1:0] OP_MOD  = 6'd29;
    localparam logic [OP_W-1:0] OP_OPEN = 6'd30;
    localparam logic [OP_W-1:0] OP_MCMP = 6'd37;
    localparam logic [OP_W-1:0] OP_EXIT = 6'd38;

    typedef enum logic [2:0] {
        A_HOST, A_PC, A_SP, A_SPM8, A_ACC, A_TMP
    } addr_sel_t;

    typedef enum logic [2:0] {
        W_HOST, W_ACC, W_FP, W_PC8, W_MERGE
    } wdata_sel_t;

    typedef enum logic [3:0] {
        ACT_NONE, ACT_START, ACT_RESUME, ACT_IGNORE, ACT_HREAD, ACT_FETCH,
        ACT_OPER, ACT_PUSH, ACT_LEV_SP, ACT_POP, ACT_LOAD, ACT_STORE,
        ACT_HALT, ACT_MD_START, ACT_MD_DONE
    } act_t;

    typedef enum logic [1:0] {
        MD_MUL, MD_DIV, MD_MOD
    } md_op_t;

    typedef struct packed {
        logic       capture;
        act_t       act;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        logic       mem_wr;
        logic       phase;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [OP_W-1:0]  op;
        logic             run_ok;
        logic             run_host;
        logic             acc_zero;
        logic             md_done;
    } dp_stat_t;

    function automatic logic [WORD_W-1:0] sext8(input logic [7:0] b);
        return {{(WORD_W-8){b[7]}}, b};
    endfunction

endpackage

@@ hdl/smc_ram.sv @@
// ----------------------------------------------------------------------------
// smc_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module smc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/smc_muldiv.sv @@
// ----------------------------------------------------------------------------
// smc_muldiv
// Bit-serial multiplier and signed divider, one bit per cycle.
// ----------------------------------------------------------------------------
module smc_muldiv import smc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  md_op_t            mode,
    input  logic [WORD_W-1:0] op_a,
    input  logic [WORD_W-1:0] op_b,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    localparam int IT_W = $clog2(WORD_W);
    localparam logic [IT_W-1:0] LAST_IT = IT_W'(WORD_W - 1);

    logic              busy_reg, busy_next;
    logic              fin_reg, fin_next;
    logic [IT_W-1:0]   it_reg, it_next;
    md_op_t            mode_reg, mode_next;
    logic              negq_reg, negq_next;
    logic              negr_reg, negr_next;
    logic [WORD_W-1:0] q_reg, q_next;
    logic [WORD_W-1:0] r_reg, r_next;
    logic [WORD_W-1:0] d_reg, d_next;
    logic [WORD_W:0]   r_shift;
    logic [WORD_W:0]   r_diff;

    assign r_shift = {r_reg, q_reg[WORD_W-1]};
    assign r_diff  = r_shift - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        it_next   = it_reg;
        mode_next = mode_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            it_next   = '0;
            mode_next = mode;
            negq_next = op_a[WORD_W-1] ^ op_b[WORD_W-1];
            negr_next = op_a[WORD_W-1];
            r_next    = '0;
            if (mode == MD_MUL)
            begin
                q_next = op_b;
                d_next = op_a;
            end
            else
            begin
                q_next = op_a[WORD_W-1] ? (~op_a + 1'b1) : op_a;
                d_next = op_b[WORD_W-1] ? (~op_b + 1'b1) : op_b;
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg == MD_MUL)
            begin
                r_next = r_reg + (q_reg[0] ? d_reg : '0);
                d_next = d_reg << 1;
                q_next = q_reg >> 1;
            end
            else if (!r_diff[WORD_W])
            begin
                r_next = r_diff[WORD_W-1:0];
                q_next = {q_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_shift[WORD_W-1:0];
                q_next = {q_reg[WORD_W-2:0], 1'b0};
            end
            it_next = it_reg + 1'b1;
            if (it_reg == LAST_IT)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
    end

    always_comb
    begin
        case (mode_reg)
            MD_MUL:  result = r_reg;
            MD_DIV:  result = negq_reg ? (~q_reg + 1'b1) : q_reg;
            MD_MOD:  result = negr_reg ? (~r_reg + 1'b1) : r_reg;
            default: result = r_reg;
        endcase
    end

    assign done = fin_reg;

endmodule

@@ hdl/smc_datapath.sv @@
// ----------------------------------------------------------------------------
// smc_datapath
// Machine registers, word memory, ALU and multiply/divide unit.
// ----------------------------------------------------------------------------
module smc_datapath import smc_pkg::*; #(
    parameter int MEM_WORDS = SMC_MEM_WORDS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            dp_cmd,
    output dp_stat_t           dp_stat,
    input  logic [CMD_W-1:0]   opcode,
    input  logic [PC_W-1:0]    mem_addr,
    input  logic [WORD_W-1:0]  write_value,
    input  logic [PC_W-1:0]    start_pc,
    input  logic [SP_W-1:0]    start_sp,
    input  logic [SP_W-1:0]    start_bp,
    output logic [STAT_W-1:0]  status,
    output logic [WORD_W-1:0]  accumulator,
    output logic [PC_W-1:0]    pc_now,
    output logic [SP_W-1:0]    sp_now,
    output logic [SP_W-1:0]    bp_now,
    output logic [WORD_W-1:0]  read_value,
    output logic [OP_W-1:0]    executed_op,
    output logic [CNT_W-1:0]   cycle_count
);

    localparam int AW = $clog2(MEM_WORDS);

    // latched request
    logic [CMD_W-1:0]  cmd_reg;
    logic [PC_W-1:0]   haddr_reg;
    logic [WORD_W-1:0] wval_reg;
    logic [PC_W-1:0]   spc_reg;
    logic [SP_W-1:0]   ssp_reg;
    logic [SP_W-1:0]   sbp_reg;

    // machine state
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [SP_W-1:0]   fp_reg, fp_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [STAT_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [STAT_W-1:0] res_reg, res_next;
    logic [WORD_W-1:0] rv_reg, rv_next;
    logic [WORD_W-1:0] tmp_reg, tmp_next;
    logic [WORD_W-1:0] word_reg, word_next;

    logic [WORD_W-1:0]        mem_rdata;
    logic [WORD_W-1:0]        mem_wdata;
    logic [WORD_W-1:0]        addr_full;
    logic [AW-1:0]            mem_idx;
    logic [WORD_W-1:0]        alu_out;
    logic signed [WORD_W-1:0] sra_val;
    logic [WORD_W-1:0]        merged;
    logic [PC_W-1:0]          pc_plus8;
    logic [SP_W-1:0]          sp_minus8;
    logic [SP_W-1:0]          imm_words;
    logic [WORD_W-1:0]        spm8_word;
    logic [WORD_W-1:0]        pc_word;
    logic                     jsr_hit;
    logic                     op_host;
    logic                     md_done;
    logic [WORD_W-1:0]        md_result;
    md_op_t                   md_mode;

    assign pc_plus8  = pc_reg + PC_W'(8);
    assign sp_minus8 = sp_reg - SP_W'(8);
    assign imm_words = {mem_rdata[SP_W-4:0], 3'b000};
    assign op_host   = (op_reg >= OP_OPEN) && (op_reg <= OP_MCMP);

    // JSR reads its target before it pushes: a push onto the target word still wins
    assign spm8_word = WORD_W'(sp_minus8);
    assign pc_word   = WORD_W'(pc_reg);
    assign jsr_hit   = (spm8_word[AW+2:3] == pc_word[AW+2:3]);

    // memory address and write data
    always_comb
    begin
        case (dp_cmd.addr_sel)
            A_HOST:  addr_full = WORD_W'(haddr_reg);
            A_PC:    addr_full = WORD_W'(pc_reg);
            A_SP:    addr_full = WORD_W'(sp_reg);
            A_SPM8:  addr_full = WORD_W'(sp_minus8);
            A_ACC:   addr_full = acc_reg;
            A_TMP:   addr_full = tmp_reg;
            default: addr_full = WORD_W'(pc_reg);
        endcase
    end

    assign mem_idx = addr_full[AW+2:3];

    always_comb
    begin
        merged = word_reg;
        merged[{tmp_reg[2:0], 3'b000} +: 8] = acc_reg[7:0];
    end

    always_comb
    begin
        case (dp_cmd.wdata_sel)
            W_HOST:  mem_wdata = wval_reg;
            W_ACC:   mem_wdata = acc_reg;
            W_FP:    mem_wdata = WORD_W'(fp_reg);
            W_PC8:   mem_wdata = WORD_W'(pc_plus8);
            W_MERGE: mem_wdata = merged;
            default: mem_wdata = acc_reg;
        endcase
    end

    smc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (dp_cmd.mem_wr),
        .addr  (mem_idx),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // ALU on popped operand and accumulator
    assign sra_val = $signed(mem_rdata) >>> acc_reg[5:0];

    always_comb
    begin
        case (op_reg)
            OP_OR:   alu_out = mem_rdata | acc_reg;
            OP_XOR:  alu_out = mem_rdata ^ acc_reg;
            OP_AND:  alu_out = mem_rdata & acc_reg;
            OP_EQ:   alu_out = WORD_W'(mem_rdata == acc_reg);
            OP_NE:   alu_out = WORD_W'(mem_rdata != acc_reg);
            OP_LT:   alu_out = WORD_W'($signed(mem_rdata) < $signed(acc_reg));
            OP_GT:   alu_out = WORD_W'($signed(acc_reg) < $signed(mem_rdata));
            OP_LE:   alu_out = WORD_W'(!($signed(acc_reg) < $signed(mem_rdata)));
            OP_GE:   alu_out = WORD_W'(!($signed(mem_rdata) < $signed(acc_reg)));
            OP_SHL:  alu_out = (|acc_reg[WORD_W-1:6]) ? '0 : (mem_rdata << acc_reg[5:0]);
            OP_SHR:  alu_out = (|acc_reg[WORD_W-1:6]) ? {WORD_W{mem_rdata[WORD_W-1]}}
                                                        : sra_val;
            OP_ADD:  alu_out = mem_rdata + acc_reg;
            OP_SUB:  alu_out = mem_rdata - acc_reg;
            default: alu_out = acc_reg;
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_MUL:  md_mode = MD_MUL;
            OP_DIV:  md_mode = MD_DIV;
            default: md_mode = MD_MOD;
        endcase
    end

    smc_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dp_cmd.act == ACT_MD_START),
        .mode   (md_mode),
        .op_a   (tmp_reg),
        .op_b   (acc_reg),
        .done   (md_done),
        .result (md_result)
    );

    // register updates per controller action
    always_comb
    begin
        pc_next   = pc_reg;
        sp_next   = sp_reg;
        fp_next   = fp_reg;
        acc_next  = acc_reg;
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        res_next  = res_reg;
        rv_next   = rv_reg;
        tmp_next  = tmp_reg;
        word_next = word_reg;
        if (dp_cmd.capture)
        begin
            res_next = ST_OK;
            rv_next  = '0;
            op_next  = '0;
        end
        case (dp_cmd.act)
            ACT_START:
            begin
                pc_next  = spc_reg;
                sp_next  = ssp_reg;
                fp_next  = sbp_reg;
                acc_next = '0;
                cnt_next = '0;
                run_next = ST_OK;
            end
            ACT_RESUME:
            begin
                acc_next = wval_reg;
                run_next = ST_OK;
            end
            ACT_IGNORE:
            begin
                res_next = ST_IDLE;
            end
            ACT_HREAD:
            begin
                rv_next = mem_rdata;
            end
            ACT_FETCH:
            begin
                op_next  = (|mem_rdata[WORD_W-1:OP_W]) ? {OP_W{1'b1}} : mem_rdata[OP_W-1:0];
                pc_next  = pc_plus8;
                cnt_next = cnt_reg + 1'b1;
            end
            ACT_OPER:
            begin
                case (op_reg)
                    OP_LEA:
                    begin
                        acc_next = WORD_W'(fp_reg) + {mem_rdata[WORD_W-4:0], 3'b000};
                        pc_next  = pc_plus8;
                    end
                    OP_IMM:
                    begin
                        acc_next = mem_rdata;
                        pc_next  = pc_plus8;
                    end
                    OP_JMP:
                    begin
                        pc_next = mem_rdata[PC_W-1:0];
                    end
                    OP_JSR:
                    begin
                        tmp_next = jsr_hit ? WORD_W'(pc_plus8) : mem_rdata;
                    end
                    OP_BZ, OP_BNZ:
                    begin
                        if ((acc_reg != '0) == (op_reg == OP_BZ))
                        begin
                            pc_next = pc_plus8;
                        end
                        else
                        begin
                            pc_next = mem_rdata[PC_W-1:0];
                        end
                    end
                    OP_ENT:
                    begin
                        pc_next = pc_plus8;
                        sp_next = sp_reg - imm_words;
                    end
                    OP_ADJ:
                    begin
                        pc_next = pc_plus8;
                        sp_next = sp_reg + imm_words;
                    end
                    default:
                    begin
                        pc_next = pc_reg;
                    end
                endcase
            end
            ACT_PUSH:
            begin
                sp_next = sp_minus8;
                if (op_reg == OP_ENT)
                begin
                    fp_next = sp_minus8;
                end
                if (op_reg == OP_JSR)
                begin
                    pc_next = tmp_reg[PC_W-1:0];
                end
            end
            ACT_LEV_SP:
            begin
                sp_next = fp_reg;
            end
            ACT_POP:
            begin
                sp_next = sp_reg + SP_W'(8);
                if (op_reg == OP_LEV)
                begin
                    if (dp_cmd.phase)
                    begin
                        pc_next = mem_rdata[PC_W-1:0];
                    end
                    else
                    begin
                        fp_next = mem_rdata[SP_W-1:0];
                    end
                end
                else if ((op_reg >= OP_OR) && (op_reg <= OP_SUB))
                begin
                    acc_next = alu_out;
                end
                else
                begin
                    tmp_next = mem_rdata;
                end
            end
            ACT_LOAD:
            begin
                case (op_reg)
                    OP_LI: acc_next = mem_rdata;
                    OP_LC: acc_next = sext8(mem_rdata[{acc_reg[2:0], 3'b000} +: 8]);
                    OP_SC: word_next = mem_rdata;
                    OP_EXIT:
                    begin
                        rv_next  = mem_rdata;
                        res_next = ST_EXIT;
                        run_next = ST_EXIT;
                    end
                    default: word_next = word_reg;
                endcase
            end
            ACT_STORE:
            begin
                if (op_reg == OP_SC)
                begin
                    acc_next = sext8(acc_reg[7:0]);
                end
            end
            ACT_HALT:
            begin
                if (op_host)
                begin
                    res_next = ST_HOST;
                    run_next = ST_HOST;
                end
                else if ((op_reg == OP_DIV) || (op_reg == OP_MOD))
                begin
                    res_next = ST_DIVZ;
                    run_next = ST_DIVZ;
                end
                else
                begin
                    res_next = ST_UNKNOWN;
                    run_next = ST_UNKNOWN;
                end
            end
            ACT_MD_DONE:
            begin
                acc_next = md_result;
            end
            default:
            begin
                acc_next = acc_next;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= '0;
            sp_reg  <= '0;
            fp_reg  <= '0;
            acc_reg <= '0;
            run_reg <= ST_IDLE;
            cnt_reg <= '0;
            op_reg  <= '0;
            res_reg <= ST_OK;
            rv_reg  <= '0;
            cmd_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            sp_reg  <= sp_next;
            fp_reg  <= fp_next;
            acc_reg <= acc_next;
            run_reg <= run_next;
            cnt_reg <= cnt_next;
            op_reg  <= op_next;
            res_reg <= res_next;
            rv_reg  <= rv_next;
            if (dp_cmd.capture)
            begin
                cmd_reg <= opcode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg  <= tmp_next;
        word_reg <= word_next;
        if (dp_cmd.capture)
        begin
            haddr_reg <= mem_addr;
            wval_reg  <= write_value;
            spc_reg   <= start_pc;
            ssp_reg   <= start_sp;
            sbp_reg   <= start_bp;
        end
    end

    assign dp_stat.cmd      = cmd_reg;
    assign dp_stat.op       = op_reg;
    assign dp_stat.run_ok   = (run_reg == ST_OK);
    assign dp_stat.run_host = (run_reg == ST_HOST);
    assign dp_stat.acc_zero = (acc_reg == '0);
    assign dp_stat.md_done  = md_done;

    assign status      = res_reg;
    assign accumulator = acc_reg;
    assign pc_now      = pc_reg;
    assign sp_now      = sp_reg;
    assign bp_now      = fp_reg;
    assign read_value  = rv_reg;
    assign executed_op = op_reg;
    assign cycle_count = cnt_reg;

endmodule

@@ hdl/smc_ctrl.sv @@
// ----------------------------------------------------------------------------
// smc_ctrl
// Sequencer: walks each request through its memory accesses and actions.
// ----------------------------------------------------------------------------
`include "stack_machine_core_top_defines.svh"

module smc_ctrl import smc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    input  dp_stat_t dp_stat,
    output dp_cmd_t  dp_cmd
);

    typedef enum logic [18:0] {
        S_IDLE   = 19'd1,
        S_DISP   = 19'd2,
        S_HWR    = 19'd4,
        S_HRD    = 19'd8,
        S_HRDW   = 19'd16,
        S_FETCH  = 19'd32,
        S_FETCHW = 19'd64,
        S_DECODE = 19'd128,
        S_RDPC   = 19'd256,
        S_RDPCW  = 19'd512,
        S_PUSH   = 19'd1024,
        S_POP    = 19'd2048,
        S_POPW   = 19'd4096,
        S_RDM    = 19'd8192,
        S_RDMW   = 19'd16384,
        S_WRM    = 19'd32768,
        S_MD     = 19'd65536,
        S_MDW    = 19'd131072,
        S_RESP   = 19'd262144
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   accept;
    logic   op_alu;

    assign accept    = (state_reg == S_IDLE) && cmd_valid;
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);
    assign op_alu    = (dp_stat.op >= OP_OR) && (dp_stat.op <= OP_SUB);

    always_comb
    begin
        state_next          = state_reg;
        phase_next          = phase_reg;
        dp_cmd.capture      = accept;
        dp_cmd.act          = ACT_NONE;
        dp_cmd.addr_sel     = A_PC;
        dp_cmd.wdata_sel    = W_ACC;
        dp_cmd.mem_wr       = 1'b0;
        dp_cmd.phase        = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_RESP;
                case (dp_stat.cmd)
                    CMD_WRITE: state_next = S_HWR;
                    CMD_READ:  state_next = S_HRD;
                    CMD_START: dp_cmd.act = ACT_START;
                    CMD_STEP:
                    begin
                        if (dp_stat.run_ok)
                        begin
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            dp_cmd.act = ACT_IGNORE;
                        end
                    end
                    CMD_RESUME:
                    begin
                        dp_cmd.act = dp_stat.run_host ? ACT_RESUME : ACT_IGNORE;
                    end
                    default: dp_cmd.act = ACT_IGNORE;
                endcase
            end
            S_HWR:
            begin
                dp_cmd.addr_sel  = A_HOST;
                dp_cmd.wdata_sel = W_HOST;
                dp_cmd.mem_wr    = 1'b1;
                state_next       = S_RESP;
            end
            S_HRD:
            begin
                dp_cmd.addr_sel = A_HOST;
                state_next      = S_HRDW;
            end
            S_HRDW:
            begin
                dp_cmd.act = ACT_HREAD;
                state_next = S_RESP;
            end
            S_FETCH:
            begin
                dp_cmd.addr_sel = A_PC;
                state_next      = S_FETCHW;
            end
            S_FETCHW:
            begin
                dp_cmd.act = ACT_FETCH;
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (dp_stat.op)
                    OP_LEA, OP_IMM, OP_JMP, OP_JSR, OP_BZ, OP_BNZ, OP_ADJ:
                        state_next = S_RDPC;
                    OP_ENT, OP_PSH:
                        state_next = S_PUSH;
                    OP_LEV:
                    begin
                        dp_cmd.act = ACT_LEV_SP;
                        phase_next = 1'b0;
                        state_next = S_POP;
                    end
                    OP_LI, OP_LC, OP_EXIT:
                        state_next = S_RDM;
                    OP_SI, OP_SC, OP_MUL:
                        state_next = S_POP;
                    OP_DIV, OP_MOD:
                    begin
                        if (dp_stat.acc_zero)
                        begin
                            dp_cmd.act = ACT_HALT;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    default:
                    begin
                        if (op_alu)
                        begin
                            state_next = S_POP;
                        end
                        else
                        begin
                            dp_cmd.act = ACT_HALT;
                            state_next = S_RESP;
                        end
                    end
                endcase
            end
            S_RDPC:
            begin
                dp_cmd.addr_sel = A_PC;
                state_next      = S_RDPCW;
            end
            S_RDPCW:
            begin
                dp_cmd.act = ACT_OPER;
                state_next = (dp_stat.op == OP_JSR) ? S_PUSH : S_RESP;
            end
            S_PUSH:
            begin
                dp_cmd.act      = ACT_PUSH;
                dp_cmd.addr_sel = A_SPM8;
                dp_cmd.mem_wr   = 1'b1;
                case (dp_stat.op)
                    OP_JSR:  dp_cmd.wdata_sel = W_PC8;
                    OP_ENT:  dp_cmd.wdata_sel = W_FP;
                    default: dp_cmd.wdata_sel = W_ACC;
                endcase
                state_next = (dp_stat.op == OP_ENT) ? S_RDPC : S_RESP;
            end
            S_POP:
            begin
                dp_cmd.addr_sel = A_SP;
                state_next      = S_POPW;
            end
            S_POPW:
            begin
                dp_cmd.act = ACT_POP;
                case (dp_stat.op)
                    OP_LEV:
                    begin
                        phase_next = 1'b1;
                        state_next = phase_reg ? S_RESP : S_POP;
                    end
                    OP_SI:                  state_next = S_WRM;
                    OP_SC:                  state_next = S_RDM;
                    OP_MUL, OP_DIV, OP_MOD: state_next = S_MD;
                    default:                state_next = S_RESP;
                endcase
            end
            S_RDM:
            begin
                case (dp_stat.op)
                    OP_SC:   dp_cmd.addr_sel = A_TMP;
                    OP_EXIT: dp_cmd.addr_sel = A_SP;
                    default: dp_cmd.addr_sel = A_ACC;
                endcase
                state_next = S_RDMW;
            end
            S_RDMW:
            begin
                dp_cmd.act = ACT_LOAD;
                state_next = (dp_stat.op == OP_SC) ? S_WRM : S_RESP;
            end
            S_WRM:
            begin
                dp_cmd.act       = ACT_STORE;
                dp_cmd.addr_sel  = A_TMP;
                dp_cmd.mem_wr    = 1'b1;
                dp_cmd.wdata_sel = (dp_stat.op == OP_SC) ? W_MERGE : W_ACC;
                state_next       = S_RESP;
            end
            S_MD:
            begin
                dp_cmd.act = ACT_MD_START;
                state_next = S_MDW;
            end
            S_MDW:
            begin
                if (dp_stat.md_done)
                begin
                    dp_cmd.act = ACT_MD_DONE;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    `SMC_ASSERT_NEXT(a_accept_dispatch, accept, state_reg == S_DISP,
        "accepted request did not reach dispatch")
    `SMC_ASSERT_NEXT(a_step_idle_resp,
        (state_reg == S_DISP) && (dp_stat.cmd == CMD_STEP) && !dp_stat.run_ok,
        (state_reg == S_RESP), "step on halted core did not answer at once")
    `SMC_ASSERT_NEXT(a_md_wait, (state_reg == S_MDW) && !dp_stat.md_done,
        state_reg == S_MDW, "left divide wait before the unit finished")
    `SMC_ASSERT_NOW(a_no_write_on_idle, state_reg == S_IDLE, !dp_cmd.mem_wr,
        "memory write issued with no request in flight")

endmodule

@@ hdl/stack_machine_core_top.sv @@
// ----------------------------------------------------------------------------
// stack_machine_core_top
// Stack machine core with accumulator and unified code/stack word memory.
// ----------------------------------------------------------------------------
// One request is in flight at a time: cmd_stall is high from acceptance until
// the response has been taken. A host write passes through dispatch and a
// memory write, a host read through dispatch and a registered memory read,
// start and resume through dispatch alone; a step's duration depends on how
// many single-port memory accesses the instruction needs (fetch, operand,
// pops and pushes), and MUL, DIV and MOD with a nonzero divisor also wait for
// the bit-serial multiply/divide unit. MEM_WORDS must be a power of two; word
// addresses wrap modulo MEM_WORDS. Memory contents are undefined after reset
// and there is no clearing pass; reset clears pc, sp, bp, the accumulator, the
// counter, opcode, command and read value, sets status OK and run state idle.
// ----------------------------------------------------------------------------
module stack_machine_core_top import smc_pkg::*; #(
    parameter int MEM_WORDS = SMC_MEM_WORDS
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic [CMD_W-1:0]  opcode,
    input  logic [PC_W-1:0]   mem_addr,
    input  logic [WORD_W-1:0] write_value,
    input  logic [PC_W-1:0]   start_pc,
    input  logic [SP_W-1:0]   start_sp,
    input  logic [SP_W-1:0]   start_bp,
    // response channel
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [STAT_W-1:0] status,
    output logic [WORD_W-1:0] accumulator,
    output logic [PC_W-1:0]   pc_now,
    output logic [SP_W-1:0]   sp_now,
    output logic [SP_W-1:0]   bp_now,
    output logic [WORD_W-1:0] read_value,
    output logic [OP_W-1:0]   executed_op,
    output logic [CNT_W-1:0]  cycle_count
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencer: drives the handshakes and tells the datapath what to do
    smc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    // datapath: registers, memory and arithmetic; outputs hold while stalled
    smc_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat),
        .opcode      (opcode),
        .mem_addr    (mem_addr),
        .write_value (write_value),
        .start_pc    (start_pc),
        .start_sp    (start_sp),
        .start_bp    (start_bp),
        .status      (status),
        .accumulator (accumulator),
        .pc_now      (pc_now),
        .sp_now      (sp_now),
        .bp_now      (bp_now),
        .read_value  (read_value),
        .executed_op (executed_op),
        .cycle_count (cycle_count)
    );

endmodule
